>>> design/goccc_pkg.sv
package goccc_pkg;

  localparam int COORD_W     = 24;
  localparam int DEV_W       = 16;
  localparam int IDX_W       = 16;
  localparam int GRID_DEPTH  = 65536;
  localparam int CIRCLE_BITS = 24;
  localparam int SCALE_FRAC  = 16;
  localparam int GRID_W      = 9;
  localparam int SPD_W       = 7;
  localparam int ORG_W       = 9;
  localparam int SCALE_W     = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_CORRECT = 2'd1;
  localparam logic [1:0] OP_DEVIATE = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPD        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_SCALE = 3'd5;

  typedef struct packed {
    logic [1:0]                op;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic [IDX_W-1:0]          entry_index;
    logic signed [DEV_W-1:0]   entry_dev_x;
    logic signed [DEV_W-1:0]   entry_dev_y;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic                      saturated;
  } out_item_t;

  // clamp a grid dimension to 2..lim, with lim capped at 511
  function automatic logic [GRID_W-1:0] eff_size(logic [GRID_W-1:0] n, int unsigned lim);
    logic [GRID_W-1:0] l;
    l = (lim > 511) ? 9'd511 : GRID_W'(lim);
    if (n < 9'd2) begin
      return 9'd2;
    end else if (n > l) begin
      return l;
    end
    return n;
  endfunction

endpackage

>>> design/goccc_ram.sv
module goccc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/goccc_pos.sv
module goccc_pos #(
  parameter int FRAC_BITS = 16,
  parameter int MAX_N = 256
) (
  input  logic                                     clk,
  input  logic                                     adv,
  input  logic signed [goccc_pkg::COORD_W-1:0]     p,
  input  logic signed [goccc_pkg::ORG_W-1:0]       origin,
  input  logic [goccc_pkg::SPD_W-1:0]              spd,
  input  logic [goccc_pkg::GRID_W-1:0]             n_cfg,
  output logic [goccc_pkg::GRID_W-1:0]             idx_r,
  output logic [FRAC_BITS-1:0]                     frac_r
);

  localparam int PROD_W = goccc_pkg::COORD_W + 17;
  localparam int ORGP_W = 17;
  localparam int SH     = goccc_pkg::CIRCLE_BITS - FRAC_BITS;
  localparam int POS_W  = 18 + FRAC_BITS;
  localparam int INT_W  = POS_W - 1 - FRAC_BITS;

  logic [15:0]                     k_u;
  logic signed [PROD_W-1:0]        prod_nxt, prod_r;
  logic signed [ORGP_W-1:0]        org_nxt, org_r;
  logic signed [POS_W-1:0]         pos;
  logic [INT_W-1:0]                ipart;
  logic [goccc_pkg::GRID_W-1:0]    lim;
  logic [goccc_pkg::GRID_W-1:0]    idx_nxt;
  logic [FRAC_BITS-1:0]            frac_nxt;

  assign k_u      = 16'(spd) * 16'd360;
  assign prod_nxt = PROD_W'(p) * PROD_W'($signed({1'b0, k_u}));
  assign org_nxt  = ORGP_W'(origin) * ORGP_W'($signed({1'b0, spd}));

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
      org_r  <= org_nxt;
    end
  end

  // floor to FRAC_BITS fraction bits, then move to the grid origin
  assign pos   = POS_W'(prod_r >>> SH) - (POS_W'(org_r) <<< FRAC_BITS);
  assign ipart = pos[POS_W-2:FRAC_BITS];
  assign lim   = goccc_pkg::eff_size(n_cfg, MAX_N) - 9'd2;

  always_comb begin
    idx_nxt  = '0;
    frac_nxt = '0;
    if (pos <= 0) begin
      idx_nxt  = '0;
      frac_nxt = '0;
    end else if (ipart > INT_W'(lim)) begin
      idx_nxt  = lim;
      frac_nxt = '0;
    end else begin
      idx_nxt  = ipart[goccc_pkg::GRID_W-1:0];
      frac_nxt = pos[FRAC_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx_r  <= idx_nxt;
      frac_r <= frac_nxt;
    end
  end

endmodule

>>> design/goccc_scale.sv
module goccc_scale #(
  parameter int FRAC_BITS = 16,
  localparam int WW = 2 * FRAC_BITS + 1
) (
  input  logic                                 clk,
  input  logic                                 adv,
  input  logic [3:0][goccc_pkg::DEV_W-1:0]     dev,
  input  logic [3:0][WW-1:0]                   wt,
  input  logic [goccc_pkg::SCALE_W-1:0]        unit_scale,
  output logic signed [33:0]                   d_r
);

  localparam int PW = 2 * FRAC_BITS + 18;
  localparam int MW = 2 * FRAC_BITS + 16;
  localparam int HW = (MW + 1) / 2;
  localparam int S  = 2 * FRAC_BITS + goccc_pkg::SCALE_FRAC;
  localparam int FW = MW + goccc_pkg::SCALE_W + 1;

  logic signed [PW-1:0]                      prod_r [4];
  logic signed [PW-1:0]                      sum_r;
  logic signed [PW-1:0]                      abs_v;
  logic [MW-1:0]                             mag_r;
  logic                                      neg7_r, neg8_r, neg9_r;
  logic [HW+goccc_pkg::SCALE_W-1:0]          pl_r;
  logic [MW-HW+goccc_pkg::SCALE_W-1:0]       ph_r;
  logic [FW-1:0]                             full;
  logic [32:0]                               r_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        prod_r[k] <= PW'($signed(dev[k])) * PW'($signed({1'b0, wt[k]}));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r <= prod_r[0] + prod_r[1] + prod_r[2] + prod_r[3];
    end
  end

  assign abs_v = sum_r[PW-1] ? -sum_r : sum_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      neg7_r <= sum_r[PW-1];
      mag_r  <= abs_v[MW-1:0];
    end
  end

  // split the magnitude so each product stays narrow
  always_ff @(posedge clk) begin
    if (adv) begin
      neg8_r <= neg7_r;
      pl_r   <= (HW + goccc_pkg::SCALE_W)'(mag_r[HW-1:0]) *
                (HW + goccc_pkg::SCALE_W)'(unit_scale);
      ph_r   <= (MW - HW + goccc_pkg::SCALE_W)'(mag_r[MW-1:HW]) *
                (MW - HW + goccc_pkg::SCALE_W)'(unit_scale);
    end
  end

  // round half away from zero on the magnitude
  assign full = (FW'(ph_r) << HW) + FW'(pl_r) + (FW'(1) << (S - 1));

  always_ff @(posedge clk) begin
    if (adv) begin
      neg9_r <= neg8_r;
      r_r    <= full[FW-1:S];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r <= neg9_r ? -$signed({1'b0, r_r}) : $signed({1'b0, r_r});
    end
  end

endmodule

>>> design/grid_offset_coordinate_correction_core.sv
// Channel  Ports                          Moves
// in       in_valid/in_ready/in_data      one op: grid load, correct or deviate
// out      out_valid/out_ready/out_data   one corrected point for ops 1 and 2
// cfg      cfg_we/cfg_index/cfg_wdata     register write, no wait
//
// One item per cycle while the output is not stalled; a point leaves through the vld_r stages and the output register.
// Four copies of the grid memory, written together, give the four corner reads in parallel.
// Loads write at the read stage, so later points see them in order.
// A stalled output freezes the whole pipe; reset clears valid bits and restores config defaults only.
module grid_offset_coordinate_correction_core #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  goccc_pkg::in_item_t                    in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output goccc_pkg::out_item_t                   out_data,
  input  logic                                   cfg_we,
  input  logic [goccc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [goccc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int NST = 10;
  localparam int WW  = 2 * FRAC_BITS + 1;
  localparam int AW  = $clog2(goccc_pkg::GRID_DEPTH);

  typedef struct packed {
    logic [1:0]                           op;
    logic signed [goccc_pkg::COORD_W-1:0] px;
    logic signed [goccc_pkg::COORD_W-1:0] py;
  } meta_t;

  typedef struct packed {
    logic [goccc_pkg::IDX_W-1:0] index;
    logic [goccc_pkg::DEV_W-1:0] dev_x;
    logic [goccc_pkg::DEV_W-1:0] dev_y;
  } entry_t;

  logic signed [8:0]                 org_x_r;
  logic signed [7:0]                 org_y_r;
  logic [goccc_pkg::SPD_W-1:0]       spd_r;
  logic [goccc_pkg::GRID_W-1:0]      cols_r, rows_r;
  logic [goccc_pkg::SCALE_W-1:0]     uscale_r;

  logic                              adv;
  logic [NST:1]                      vld_r;
  meta_t                             meta_r [1:NST];
  entry_t                            ent_r [1:3];

  logic [goccc_pkg::GRID_W-1:0]      ix, iy, cols_eff;
  logic [FRAC_BITS-1:0]              fx, fy;
  logic [FRAC_BITS:0]                wx0, wy0;
  logic [2*goccc_pkg::GRID_W:0]      base;
  logic [3:0][AW-1:0]                addr_nxt, addr_r;
  logic [3:0][WW-1:0]                w_nxt, w3_r, w4_r;
  logic [3:0][31:0]                  rdata;
  logic [3:0][goccc_pkg::DEV_W-1:0]  dev_x, dev_y;
  logic                              ram_we;
  logic signed [33:0]                dx, dy;
  logic signed [34:0]                sx, sy;
  logic                              sat_x, sat_y;
  logic signed [goccc_pkg::COORD_W-1:0] rx, ry;
  logic                              out_valid_r;
  goccc_pkg::out_item_t              out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r  <= '0;
      org_y_r  <= '0;
      spd_r    <= 7'd1;
      cols_r   <= 9'd2;
      rows_r   <= 9'd2;
      uscale_r <= 32'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        goccc_pkg::CFG_ORIGIN_X:   org_x_r  <= cfg_wdata[8:0];
        goccc_pkg::CFG_ORIGIN_Y:   org_y_r  <= cfg_wdata[7:0];
        goccc_pkg::CFG_SPD:        spd_r    <= cfg_wdata[6:0];
        goccc_pkg::CFG_GRID_COLS:  cols_r   <= cfg_wdata[8:0];
        goccc_pkg::CFG_GRID_ROWS:  rows_r   <= cfg_wdata[8:0];
        goccc_pkg::CFG_UNIT_SCALE: uscale_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // freeze every stage while the output item waits
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta_r[1] <= '{op: in_data.op, px: in_data.coord_x, py: in_data.coord_y};
      for (int k = 2; k <= NST; k++) begin
        meta_r[k] <= meta_r[k-1];
      end
      ent_r[1] <= '{index: in_data.entry_index, dev_x: in_data.entry_dev_x,
                    dev_y: in_data.entry_dev_y};
      ent_r[2] <= ent_r[1];
      ent_r[3] <= ent_r[2];
    end
  end

  goccc_pos #(.FRAC_BITS(FRAC_BITS), .MAX_N(MAX_COLS)) u_pos_x (
    .clk(clk), .adv(adv), .p(in_data.coord_x), .origin(org_x_r), .spd(spd_r),
    .n_cfg(cols_r), .idx_r(ix), .frac_r(fx)
  );

  goccc_pos #(.FRAC_BITS(FRAC_BITS), .MAX_N(MAX_ROWS)) u_pos_y (
    .clk(clk), .adv(adv), .p(in_data.coord_y), .origin(9'(org_y_r)), .spd(spd_r),
    .n_cfg(rows_r), .idx_r(iy), .frac_r(fy)
  );

  assign cols_eff = goccc_pkg::eff_size(cols_r, MAX_COLS);
  assign base     = (2*goccc_pkg::GRID_W+1)'(iy) * (2*goccc_pkg::GRID_W+1)'(cols_eff)
                  + (2*goccc_pkg::GRID_W+1)'(ix);

  assign addr_nxt[0] = base[AW-1:0];
  assign addr_nxt[1] = base[AW-1:0] + AW'(1);
  assign addr_nxt[2] = base[AW-1:0] + AW'(cols_eff);
  assign addr_nxt[3] = base[AW-1:0] + AW'(cols_eff) + AW'(1);

  assign wx0 = (FRAC_BITS+1)'(1) << FRAC_BITS;
  assign wy0 = (FRAC_BITS+1)'(1) << FRAC_BITS;

  assign w_nxt[0] = WW'((wx0 - (FRAC_BITS+1)'(fx)) * (wy0 - (FRAC_BITS+1)'(fy)));
  assign w_nxt[1] = WW'((FRAC_BITS+1)'(fx) * (wy0 - (FRAC_BITS+1)'(fy)));
  assign w_nxt[2] = WW'((wx0 - (FRAC_BITS+1)'(fx)) * (FRAC_BITS+1)'(fy));
  assign w_nxt[3] = WW'((FRAC_BITS+1)'(fx) * (FRAC_BITS+1)'(fy));

  always_ff @(posedge clk) begin
    if (adv) begin
      addr_r <= addr_nxt;
      w3_r   <= w_nxt;
      w4_r   <= w3_r;
    end
  end

  assign ram_we = adv && vld_r[3] && (meta_r[3].op == goccc_pkg::OP_LOAD);

  for (genvar k = 0; k < 4; k++) begin : g_bank
    goccc_ram #(.WIDTH(32), .DEPTH(goccc_pkg::GRID_DEPTH)) u_ram (
      .clk(clk), .we(ram_we), .waddr(ent_r[3].index),
      .wdata({ent_r[3].dev_y, ent_r[3].dev_x}),
      .re(adv), .raddr(addr_r[k]), .rdata(rdata[k])
    );
    assign dev_x[k] = rdata[k][15:0];
    assign dev_y[k] = rdata[k][31:16];
  end

  goccc_scale #(.FRAC_BITS(FRAC_BITS)) u_scale_x (
    .clk(clk), .adv(adv), .dev(dev_x), .wt(w4_r), .unit_scale(uscale_r), .d_r(dx)
  );

  goccc_scale #(.FRAC_BITS(FRAC_BITS)) u_scale_y (
    .clk(clk), .adv(adv), .dev(dev_y), .wt(w4_r), .unit_scale(uscale_r), .d_r(dy)
  );

  always_comb begin
    if (meta_r[NST].op == goccc_pkg::OP_CORRECT) begin
      sx = 35'(meta_r[NST].px) - 35'(dx);
      sy = 35'(meta_r[NST].py) - 35'(dy);
    end else begin
      sx = 35'(meta_r[NST].px) + 35'(dx);
      sy = 35'(meta_r[NST].py) + 35'(dy);
    end
    sat_x = 1'b0;
    sat_y = 1'b0;
    rx    = sx[23:0];
    ry    = sy[23:0];
    if (sx > 35'sd8388607) begin
      rx    = 24'sd8388607;
      sat_x = 1'b1;
    end else if (sx < -35'sd8388608) begin
      rx    = -24'sd8388608;
      sat_x = 1'b1;
    end
    if (sy > 35'sd8388607) begin
      ry    = 24'sd8388607;
      sat_y = 1'b1;
    end else if (sy < -35'sd8388608) begin
      ry    = -24'sd8388608;
      sat_y = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[NST] && ((meta_r[NST].op == goccc_pkg::OP_CORRECT) ||
                                    (meta_r[NST].op == goccc_pkg::OP_DEVIATE));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= '{out_x: rx, out_y: ry, saturated: sat_x || sat_y};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
